FILE: hw/rtl/udiv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared constants and controller/datapath interface types for the divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

  // Width of the operand and result ports, in bits.
  localparam int unsigned PortBits = 64;

  // Default and largest operand width, in bytes.
  localparam int unsigned OperandBytesDef = 8;
  localparam int unsigned OperandBytesMax = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture operands, clear the partial remainder
    logic step;    // one shift-subtract iteration
    logic finish;  // move the result into the output register
  } udiv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // current step is the final quotient bit
  } udiv_sts_t;

endpackage : udiv_pkg
`default_nettype wire

FILE: hw/rtl/unsigned_shift_subtract_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_shift_subtract_divider
// Unsigned restoring divider: quotient and remainder of two operands of
// OPERAND_BYTES bytes, with a flag for a zero divisor.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  in      | sink      | in_valid_i / in_ready_o  | dividend_i, divisor_value_i
//  out     | source    | out_valid_o / out_ready_i| quotient_value_o, remainder_value_o,
//          |           |                          | divide_by_zero_o
//
// An item runs one load, one shift-subtract step per quotient bit in the
// shared subtractor, and one move of the result into the output register
// before the next item is accepted.
// Operand bits above 8*OPERAND_BYTES are ignored; results are zero-extended.
// A finished result waits in the output register while the next item runs;
// a stalled output holds the sequencer in its done state until taken.
// Reset clears the sequencer and the output valid; nothing else needs it.
// ----------------------------------------------------------------------------
module unsigned_shift_subtract_divider #(
  parameter int unsigned OPERAND_BYTES = udiv_pkg::OperandBytesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [udiv_pkg::PortBits-1:0]  dividend_i,
  input  wire logic [udiv_pkg::PortBits-1:0]  divisor_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [udiv_pkg::PortBits-1:0]  quotient_value_o,
  output logic      [udiv_pkg::PortBits-1:0]  remainder_value_o,
  output logic                                divide_by_zero_o
);
  import udiv_pkg::*;

  udiv_cmd_t cmd;
  udiv_sts_t sts;

  // Sequencer: load, step through every quotient bit, then hand off.
  udiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: partial remainder, quotient shift register, output register.
  udiv_dp #(
    .OPERAND_BYTES (OPERAND_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .dividend_i        (dividend_i),
    .divisor_value_i   (divisor_value_i),
    .quotient_value_o  (quotient_value_o),
    .remainder_value_o (remainder_value_o),
    .divide_by_zero_o  (divide_by_zero_o)
  );

endmodule : unsigned_shift_subtract_divider
`default_nettype wire

FILE: hw/rtl/udiv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_dp
// Restoring shift-subtract datapath: one quotient bit per step, plus the
// output register that holds a finished result.
// ----------------------------------------------------------------------------
module udiv_dp #(
  parameter int unsigned OPERAND_BYTES = udiv_pkg::OperandBytesDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire udiv_pkg::udiv_cmd_t               cmd_i,
  output udiv_pkg::udiv_sts_t                    sts_o,
  input  wire logic [udiv_pkg::PortBits-1:0]     dividend_i,
  input  wire logic [udiv_pkg::PortBits-1:0]     divisor_value_i,
  output logic      [udiv_pkg::PortBits-1:0]     quotient_value_o,
  output logic      [udiv_pkg::PortBits-1:0]     remainder_value_o,
  output logic                                   divide_by_zero_o
);
  import udiv_pkg::*;

  localparam int unsigned Bytes = (OPERAND_BYTES == 0) ? 1 :
                                  (OPERAND_BYTES > OperandBytesMax) ? OperandBytesMax :
                                  OPERAND_BYTES;
  localparam int unsigned W  = Bytes * 8;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dsr_q;
  logic          dz_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;
  logic          neg;

  logic [PortBits-1:0] quo_out_q, rem_out_q;
  logic                dz_out_q;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};
  assign neg   = trial[W];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = dividend_i[W-1:0];
      cnt_d = '0;
    end else if (cmd_i.step) begin
      // Keep the shifted remainder when the trial subtraction goes negative.
      rem_d = neg ? {rem_q[W-2:0], quo_q[W-1]} : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ~neg};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load) begin
      dsr_q <= divisor_value_i[W-1:0];
      dz_q  <= (divisor_value_i[W-1:0] == '0);
    end
    if (cmd_i.finish) begin
      // A zero divisor leaves the dividend in the remainder; drop the quotient.
      quo_out_q <= dz_q ? '0 : PortBits'(quo_q);
      rem_out_q <= PortBits'(rem_q);
      dz_out_q  <= dz_q;
    end
  end

  assign sts_o.last        = (cnt_q == CW'(W - 1));
  assign quotient_value_o  = quo_out_q;
  assign remainder_value_o = rem_out_q;
  assign divide_by_zero_o  = dz_out_q;

endmodule : udiv_dp
`default_nettype wire

FILE: hw/rtl/udiv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udiv_ctrl
// Sequencer: accept an item, run the steps, hand the result to the output.
// ----------------------------------------------------------------------------
module udiv_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output udiv_pkg::udiv_cmd_t       cmd_o,
  input  wire udiv_pkg::udiv_sts_t  sts_i
);
  import udiv_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun && sts_i.last) |=> (state_q == StDone))
    else $error("run did not end after the last step");

  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_q && state_q == StIdle))
    else $error("finished result not presented");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == StIdle && !cmd_o.step && !cmd_o.finish))
    else $error("load outside idle");

endmodule : udiv_ctrl
`default_nettype wire

FILE: test/unsigned_shift_subtract_divider_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_shift_subtract_divider_tb
// Self-checking bench for the unsigned divider. A queue of operand pairs
// feeds the input channel in bursts with random gaps. The output channel
// stalls on a rotating pattern. Every accepted pair is divided here with
// plain floor division at the operand width, and each result item is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module unsigned_shift_subtract_divider_tb;

  localparam int unsigned OperandBytes = udiv_pkg::OperandBytesDef;
  localparam int unsigned Bits         = udiv_pkg::PortBits;
  localparam logic [Bits-1:0] OperandMask = (OperandBytes >= 8) ? '1 :
      ((64'd1 << (OperandBytes * 8)) - 64'd1);
  // Span from one acceptance to the next, and a drain time with margin beyond it.
  localparam int unsigned ItemCycles = 8 * OperandBytes + 2;
  localparam int unsigned DrainCycles = ItemCycles + 8;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomItems = 900;

  typedef struct packed {
    logic [Bits-1:0] dividend;
    logic [Bits-1:0] divisor;
  } operand_pair_t;

  typedef struct packed {
    logic [Bits-1:0] quotient;
    logic [Bits-1:0] remainder;
    logic            div_zero;
  } quot_rem_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [Bits-1:0] dividend_i = '0;
  logic [Bits-1:0] divisor_value_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [Bits-1:0] quotient_value_o;
  logic [Bits-1:0] remainder_value_o;
  logic            divide_by_zero_o;

  operand_pair_t operand_queue[$];
  quot_rem_t     quot_rem_due[$];
  operand_pair_t next_pair;
  quot_rem_t     got_result;
  quot_rem_t     want_result;

  logic          in_taken = 1'b0;
  int unsigned   burst_left = 0;
  int unsigned   gap_left = 0;
  logic [15:0]   stall_pat = 16'hffff;
  int unsigned   stall_age = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   error_count = 0;

  unsigned_shift_subtract_divider #(
    .OPERAND_BYTES(OperandBytes)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .dividend_i       (dividend_i),
    .divisor_value_i  (divisor_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_value_o (quotient_value_o),
    .remainder_value_o(remainder_value_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  // Floor division at the operand width; a zero divisor flags and passes
  // the truncated dividend through as the remainder.
  function automatic quot_rem_t divide_floor(logic [Bits-1:0] num, logic [Bits-1:0] den);
    quot_rem_t       res;
    logic [Bits-1:0] num_t;
    logic [Bits-1:0] den_t;
    num_t = num & OperandMask;
    den_t = den & OperandMask;
    if (den_t == '0) begin
      res.quotient  = '0;
      res.remainder = num_t;
      res.div_zero  = 1'b1;
    end else begin
      res.quotient  = num_t / den_t;
      res.remainder = num_t % den_t;
      res.div_zero  = 1'b0;
    end
    return res;
  endfunction

  // Random operand of random significant width, sometimes all ones.
  function automatic logic [Bits-1:0] rand_operand();
    int unsigned     width;
    logic [Bits-1:0] value;
    width = ($urandom_range(0, 3) == 0) ? Bits : $urandom_range(1, Bits);
    value = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
    if (width < Bits) value &= (64'd1 << width) - 64'd1;
    return value;
  endfunction

  function automatic void add_pair(logic [Bits-1:0] num, logic [Bits-1:0] den);
    operand_pair_t p;
    p.dividend = num;
    p.divisor  = den;
    operand_queue.push_back(p);
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sender: bursts of items separated by random gaps, including bursts with
  // no gap at all so that items arrive back to back.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (operand_queue.size() != 0) begin
          next_pair       = operand_queue.pop_front();
          dividend_i      <= next_pair.dividend;
          divisor_value_i <= next_pair.divisor;
          in_valid_i      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotate a 16-bit ready pattern, reload it each time stall_age wraps.
  // An all-ones pattern gives stretches without stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= stall_pat[0];
      if (stall_age == 127) begin
        stall_age <= 0;
        case ($urandom_range(0, 3))
          0: begin
            stall_pat <= 16'hffff;
          end
          1: begin
            stall_pat <= 16'($urandom) | 16'h0001;
          end
          2: begin
            stall_pat <= (16'($urandom) & 16'($urandom)) | 16'h0001;
          end
          default: begin
            stall_pat <= 16'($urandom) | 16'($urandom);
          end
        endcase
      end else begin
        stall_age <= stall_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        quot_rem_due.push_back(divide_floor(dividend_i, divisor_value_i));
      end
      if (out_valid_o && out_ready_i) begin
        got_result.quotient  = quotient_value_o;
        got_result.remainder = remainder_value_o;
        got_result.div_zero  = divide_by_zero_o;
        if (quot_rem_due.size() == 0) begin
          $display("%0t: unexpected result q=%h r=%h dbz=%b", $time,
                   got_result.quotient, got_result.remainder, got_result.div_zero);
          error_count++;
        end else begin
          want_result = quot_rem_due.pop_front();
          if (got_result.quotient !== want_result.quotient) begin
            $display("%0t: quotient_value expected %h actual %h", $time,
                     want_result.quotient, got_result.quotient);
            error_count++;
          end
          if (got_result.remainder !== want_result.remainder) begin
            $display("%0t: remainder_value expected %h actual %h", $time,
                     want_result.remainder, got_result.remainder);
            error_count++;
          end
          if (got_result.div_zero !== want_result.div_zero) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     want_result.div_zero, got_result.div_zero);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run once nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: extremes, zero divisor, zero dividend, equal operands,
    // divisor above dividend, powers of two.
    add_pair('1, '1);
    add_pair('1, 64'd1);
    add_pair('1, 64'd2);
    add_pair('1, 64'h8000_0000_0000_0000);
    add_pair('1, 64'h0000_0000_ffff_ffff);
    add_pair(64'h8000_0000_0000_0000, 64'd3);
    add_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_pair('1 - 64'd1, '1);
    add_pair(64'd1, '1);
    add_pair(64'd0, 64'd5);
    add_pair(64'd0, '1);
    add_pair(64'd0, 64'd0);
    add_pair('1, 64'd0);
    add_pair(64'd123, 64'd0);
    add_pair(64'd5, 64'd7);
    add_pair(64'd7, 64'd7);
    add_pair(64'd1, 64'd1);
    add_pair(64'd100, 64'd10);
    add_pair(64'd12345678901234, 64'd97);
    add_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    add_pair(64'haaaa_aaaa_aaaa_aaaa, 64'h0000_0000_0000_0003);
    // Random: mixed widths, with occasional zero, equal and power-of-two
    // divisors and zero dividends.
    for (int n = 0; n < RandomItems; n++) begin
      logic [Bits-1:0] num;
      logic [Bits-1:0] den;
      num = ($urandom_range(0, 30) == 0) ? '0 : rand_operand();
      case ($urandom_range(0, 19))
        0: den = '0;
        1: den = num;
        2: den = 64'd1 << $urandom_range(0, Bits - 1);
        3: den = num + 64'd1;
        default: den = rand_operand();
      endcase
      add_pair(num, den);
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (operand_queue.size() != 0 || in_valid_i || quot_rem_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : unsigned_shift_subtract_divider_tb
`default_nettype wire
